/* src/apsq_pkg.sv */
`timescale 1ns / 1ps

package apsq_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int DRIVE_SLOTS      = 4;
  localparam int MAX_RESULTS      = 8;
  localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W            = $clog2(MAX_RESULTS);
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 1'd1;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] ACT_PORT   = 2'd0;
  localparam logic [1:0] ACT_STATUS = 2'd1;
  localparam logic [1:0] ACT_DATA   = 2'd2;
  localparam logic [1:0] ACT_DONE   = 2'd3;

  localparam logic [9:0] PORT_BASE_PRI = 10'h1F0;
  localparam logic [9:0] PORT_BASE_SEC = 10'h170;

  localparam logic [9:0] OFS_DATA     = 10'd0;
  localparam logic [9:0] OFS_FEATURES = 10'd1;
  localparam logic [9:0] OFS_COUNT    = 10'd2;
  localparam logic [9:0] OFS_LBA_LO   = 10'd3;
  localparam logic [9:0] OFS_LBA_MID  = 10'd4;
  localparam logic [9:0] OFS_LBA_HI   = 10'd5;
  localparam logic [9:0] OFS_DEVICE   = 10'd6;
  localparam logic [9:0] OFS_COMMAND  = 10'd7;

  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;

  localparam logic [7:0] DEV_LBA   = 8'h40;
  localparam logic [7:0] DEV_SLAVE = 8'h10;

  localparam logic [7:0] STS_BSY  = 8'h80;
  localparam logic [7:0] STS_DF   = 8'h20;
  localparam logic [7:0] STS_DRQ  = 8'h08;
  localparam logic [7:0] STS_ERR  = 8'h01;
  localparam logic [7:0] STS_NONE = 8'h00;
  localparam logic [7:0] STS_FLOAT = 8'hFF;

  localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WAIT_READY,
    PH_WAIT_DRQ,
    PH_TRANSFER,
    PH_WAIT_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [1:0]  drive_num;
    logic [27:0] lba;
    logic [7:0]  sector_cnt;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  port;
    logic [15:0] value;
    logic        success;
    logic        last;
  } out_item_t;

  typedef out_item_t [MAX_RESULTS-1:0] res_list_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  active_op;
    logic [1:0]  active_drive;
    logic [27:0] start_block;
    logic [7:0]  sectors_left;
    logic [8:0]  word_index;
    logic [15:0] poll_count;
  } seq_state_t;

  function automatic out_item_t mk_item(logic [1:0] action, logic [9:0] port,
                                        logic [15:0] value, logic success);
    out_item_t r;
    r.action  = action;
    r.port    = port;
    r.value   = value;
    r.success = success;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

/* src/apsq_step.sv */
`timescale 1ns / 1ps

module apsq_step (
  input  apsq_pkg::in_item_t               item,
  input  apsq_pkg::seq_state_t             cur,
  input  logic [apsq_pkg::DRIVE_SLOTS-1:0] drive_mask,
  input  logic [15:0]                      poll_limit,
  output apsq_pkg::seq_state_t             state_next,
  output apsq_pkg::res_list_t              res,
  output logic [apsq_pkg::CNT_W-1:0]       res_count
);

  logic [9:0]  cur_base;
  logic [9:0]  start_base;
  logic [7:0]  sel_byte;
  logic        limit_zero;
  logic [15:0] pc_inc;
  logic        poll_timeout;
  logic [7:0]  sl_dec;
  logic [8:0]  wi_inc;
  logic        sector_end;
  logic        present;
  logic        start_bad;
  logic        drq_fail;
  logic        drq_go;
  logic        not_busy;
  logic [7:0]  st;
  apsq_pkg::out_item_t done_fail;
  apsq_pkg::out_item_t wait_item;
  apsq_pkg::out_item_t poll_item;
  apsq_pkg::out_item_t start_item;

  assign st         = item.status_byte;
  assign cur_base   = cur.active_drive[1] ? apsq_pkg::PORT_BASE_SEC : apsq_pkg::PORT_BASE_PRI;
  assign start_base = item.drive_num[1] ? apsq_pkg::PORT_BASE_SEC : apsq_pkg::PORT_BASE_PRI;
  assign sel_byte   = apsq_pkg::DEV_LBA | (cur.active_drive[0] ? apsq_pkg::DEV_SLAVE : 8'h00);
  assign limit_zero = (poll_limit == 16'd0);
  assign pc_inc     = cur.poll_count + 16'd1;
  assign poll_timeout = (pc_inc >= poll_limit);
  assign sl_dec     = cur.sectors_left - 8'd1;
  assign wi_inc     = cur.word_index + 9'd1;
  assign sector_end = ({23'd0, wi_inc} >= apsq_pkg::WORDS_PER_SECTOR);
  assign present    = ({30'd0, item.drive_num} < apsq_pkg::DRIVE_SLOTS) &&
                      drive_mask[item.drive_num];
  assign start_bad  = (item.op != apsq_pkg::OP_READ && item.op != apsq_pkg::OP_WRITE &&
                       item.op != apsq_pkg::OP_FLUSH) || !present ||
                      (item.op != apsq_pkg::OP_FLUSH && item.sector_cnt == 8'd0);
  assign not_busy   = ((st & apsq_pkg::STS_BSY) == 8'h00);
  assign drq_fail   = ((st & apsq_pkg::STS_ERR) != 8'h00) || (st == apsq_pkg::STS_NONE) ||
                      (st == apsq_pkg::STS_FLOAT) || ((st & apsq_pkg::STS_DF) != 8'h00);
  assign drq_go     = not_busy && ((st & apsq_pkg::STS_DRQ) != 8'h00);

  assign done_fail  = apsq_pkg::mk_item(apsq_pkg::ACT_DONE, 10'd0, 16'd0, 1'b0);
  assign wait_item  = limit_zero ? done_fail :
                      apsq_pkg::mk_item(apsq_pkg::ACT_STATUS,
                                        cur_base + apsq_pkg::OFS_COMMAND, 16'd0, 1'b0);
  assign start_item = limit_zero ? done_fail :
                      apsq_pkg::mk_item(apsq_pkg::ACT_STATUS,
                                        start_base + apsq_pkg::OFS_COMMAND, 16'd0, 1'b0);
  assign poll_item  = poll_timeout ? done_fail :
                      apsq_pkg::mk_item(apsq_pkg::ACT_STATUS,
                                        cur_base + apsq_pkg::OFS_COMMAND, 16'd0, 1'b0);

  always_comb begin
    state_next = cur;
    res        = '0;
    res_count  = '0;
    priority if (item.kind == apsq_pkg::KIND_START && cur.phase == apsq_pkg::PH_IDLE) begin
      res_count = apsq_pkg::CNT_W'(1);
      if (start_bad) begin
        res[0] = done_fail;
      end else begin
        state_next.active_op    = item.op;
        state_next.active_drive = item.drive_num;
        state_next.start_block  = item.lba;
        state_next.sectors_left = (item.op == apsq_pkg::OP_FLUSH) ? 8'd1 : item.sector_cnt;
        state_next.word_index   = '0;
        state_next.poll_count   = '0;
        state_next.phase        = limit_zero ? apsq_pkg::PH_IDLE : apsq_pkg::PH_WAIT_READY;
        res[0] = start_item;
      end
    end else if (item.kind == apsq_pkg::KIND_STATUS &&
                 cur.phase == apsq_pkg::PH_WAIT_READY) begin
      if (!not_busy) begin
        state_next.poll_count = pc_inc;
        if (poll_timeout) state_next.phase = apsq_pkg::PH_IDLE;
        res[0]    = poll_item;
        res_count = apsq_pkg::CNT_W'(1);
      end else begin
        state_next.poll_count = '0;
        if (cur.active_op == apsq_pkg::OP_FLUSH) begin
          res[0] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_DEVICE,
                                     {8'h00, sel_byte}, 1'b0);
          res[1] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_COMMAND,
                                     {8'h00, apsq_pkg::CMD_FLUSH}, 1'b0);
          res[2] = wait_item;
          res_count = apsq_pkg::CNT_W'(3);
          state_next.phase = limit_zero ? apsq_pkg::PH_IDLE : apsq_pkg::PH_WAIT_DONE;
        end else begin
          res[0] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_DEVICE,
                                     {8'h00, sel_byte | {4'h0, cur.start_block[27:24]}},
                                     1'b0);
          res[1] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_FEATURES,
                                     16'd0, 1'b0);
          res[2] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_COUNT,
                                     {8'h00, cur.sectors_left}, 1'b0);
          res[3] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_LBA_LO,
                                     {8'h00, cur.start_block[7:0]}, 1'b0);
          res[4] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_LBA_MID,
                                     {8'h00, cur.start_block[15:8]}, 1'b0);
          res[5] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_LBA_HI,
                                     {8'h00, cur.start_block[23:16]}, 1'b0);
          res[6] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_COMMAND,
                                     {8'h00, (cur.active_op == apsq_pkg::OP_WRITE) ?
                                      apsq_pkg::CMD_WRITE : apsq_pkg::CMD_READ}, 1'b0);
          res[7] = wait_item;
          res_count = apsq_pkg::CNT_W'(8);
          state_next.phase = limit_zero ? apsq_pkg::PH_IDLE : apsq_pkg::PH_WAIT_DRQ;
        end
      end
    end else if (item.kind == apsq_pkg::KIND_STATUS &&
                 cur.phase == apsq_pkg::PH_WAIT_DRQ) begin
      if (drq_fail) begin
        res[0]    = done_fail;
        res_count = apsq_pkg::CNT_W'(1);
        state_next.phase = apsq_pkg::PH_IDLE;
      end else if (drq_go) begin
        state_next.phase      = apsq_pkg::PH_TRANSFER;
        state_next.word_index = '0;
      end else begin
        state_next.poll_count = pc_inc;
        if (poll_timeout) state_next.phase = apsq_pkg::PH_IDLE;
        res[0]    = poll_item;
        res_count = apsq_pkg::CNT_W'(1);
      end
    end else if (item.kind == apsq_pkg::KIND_STATUS &&
                 cur.phase == apsq_pkg::PH_WAIT_DONE) begin
      res_count = apsq_pkg::CNT_W'(1);
      if (!not_busy) begin
        state_next.poll_count = pc_inc;
        if (poll_timeout) state_next.phase = apsq_pkg::PH_IDLE;
        res[0] = poll_item;
      end else begin
        state_next.sectors_left = sl_dec;
        if (sl_dec == 8'd0) begin
          res[0] = apsq_pkg::mk_item(apsq_pkg::ACT_DONE, 10'd0, 16'd0, 1'b1);
          state_next.phase = apsq_pkg::PH_IDLE;
        end else begin
          res[0] = wait_item;
          state_next.poll_count = '0;
          state_next.phase = limit_zero ? apsq_pkg::PH_IDLE : apsq_pkg::PH_WAIT_DRQ;
        end
      end
    end else if (item.kind == apsq_pkg::KIND_DATA &&
                 cur.phase == apsq_pkg::PH_TRANSFER) begin
      res_count = apsq_pkg::CNT_W'(1);
      if (cur.active_op == apsq_pkg::OP_WRITE) begin
        res[0] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_DATA,
                                   item.data_word, 1'b0);
      end else begin
        res[0] = apsq_pkg::mk_item(apsq_pkg::ACT_DATA, 10'd0, item.data_word, 1'b0);
      end
      state_next.word_index = sector_end ? 9'd0 : wi_inc;
      if (sector_end) begin
        if (cur.active_op == apsq_pkg::OP_WRITE) begin
          res[1] = apsq_pkg::mk_item(apsq_pkg::ACT_PORT, cur_base + apsq_pkg::OFS_COMMAND,
                                     {8'h00, apsq_pkg::CMD_FLUSH}, 1'b0);
          res[2] = wait_item;
          res_count = apsq_pkg::CNT_W'(3);
          state_next.poll_count = '0;
          state_next.phase = limit_zero ? apsq_pkg::PH_IDLE : apsq_pkg::PH_WAIT_DONE;
        end else begin
          res_count = apsq_pkg::CNT_W'(2);
          state_next.sectors_left = sl_dec;
          if (sl_dec == 8'd0) begin
            res[1] = apsq_pkg::mk_item(apsq_pkg::ACT_DONE, 10'd0, 16'd0, 1'b1);
            state_next.phase = apsq_pkg::PH_IDLE;
          end else begin
            res[1] = wait_item;
            state_next.poll_count = '0;
            state_next.phase = limit_zero ? apsq_pkg::PH_IDLE : apsq_pkg::PH_WAIT_DRQ;
          end
        end
      end
    end else begin
      res_count = '0;
    end
  end

endmodule

/* src/ata_pio_command_sequencer_top.sv */
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+--------------------------------
// req      | req_valid/req_ready  | apsq_pkg::in_item_t  (one word)
// rsp      | rsp_valid/rsp_ready  | apsq_pkg::out_item_t (one word)
// cfg      | cfg_we               | cfg_index, cfg_data
//
// A request word is taken into an input register, then the combinational step logic turns it
// into zero to eight response words held in a result buffer. The buffer drains one word per
// cycle while rsp_ready is high; the next request waits in the input register until the last
// word is taken, so requests yielding at most one word flow at one per cycle while rsp_ready
// stays high. A response word is offered once its request is loaded into the free result buffer.
// Synchronous reset clears the sequencer to idle, empties both stages and loads
// the config defaults (no drives present, poll limit 1000).

module ata_pio_command_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  apsq_pkg::in_item_t                req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output apsq_pkg::out_item_t               rsp,
  input  logic                              cfg_we,
  input  logic [apsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [apsq_pkg::DRIVE_SLOTS-1:0] drive_mask;
  logic [15:0]                      poll_limit;

  logic                 in_q_valid;
  apsq_pkg::in_item_t   in_q;

  apsq_pkg::seq_state_t seq_state;
  apsq_pkg::seq_state_t state_next;
  apsq_pkg::res_list_t  step_res;
  logic [apsq_pkg::CNT_W-1:0] step_count;

  apsq_pkg::res_list_t        held;
  logic [apsq_pkg::CNT_W-1:0] buf_count;
  logic [apsq_pkg::IDX_W-1:0] rd_idx;

  logic take;
  logic last_take;
  logic buf_free;
  logic move;

  apsq_step u_step (
    .item       (in_q),
    .cur        (seq_state),
    .drive_mask (drive_mask),
    .poll_limit (poll_limit),
    .state_next (state_next),
    .res        (step_res),
    .res_count  (step_count)
  );

  assign rsp_valid = (buf_count != '0);
  assign take      = rsp_valid && rsp_ready;
  assign last_take = take && (apsq_pkg::CNT_W'(rd_idx) == buf_count - apsq_pkg::CNT_W'(1));
  assign buf_free  = (buf_count == '0) || last_take;
  assign move      = in_q_valid && buf_free;
  assign req_ready = !in_q_valid || move;

  always_comb begin
    rsp      = held[rd_idx];
    rsp.last = (apsq_pkg::CNT_W'(rd_idx) == buf_count - apsq_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mask <= '0;
      poll_limit <= apsq_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apsq_pkg::CFG_DRIVE_MASK: drive_mask <= cfg_data[apsq_pkg::DRIVE_SLOTS-1:0];
        apsq_pkg::CFG_POLL_LIMIT: poll_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      in_q_valid <= 1'b1;
    end else if (move) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      in_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state.phase        <= apsq_pkg::PH_IDLE;
      seq_state.active_op    <= '0;
      seq_state.active_drive <= '0;
      seq_state.start_block  <= '0;
      seq_state.sectors_left <= '0;
      seq_state.word_index   <= '0;
      seq_state.poll_count   <= '0;
    end else if (move) begin
      seq_state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= '0;
      rd_idx    <= '0;
    end else if (move) begin
      buf_count <= step_count;
      rd_idx    <= '0;
    end else if (last_take) begin
      buf_count <= '0;
      rd_idx    <= '0;
    end else if (take) begin
      rd_idx <= rd_idx + apsq_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      held <= step_res;
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    buf_count != '0 |-> apsq_pkg::CNT_W'(rd_idx) < buf_count)
    else $error("read index past buffered words");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    buf_count <= apsq_pkg::CNT_W'(apsq_pkg::MAX_RESULTS))
    else $error("result buffer count overflow");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !move |=> seq_state.phase == $past(seq_state.phase))
    else $error("phase changed without a step");

  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    seq_state.phase == apsq_pkg::PH_TRANSFER |->
      {23'd0, seq_state.word_index} < apsq_pkg::WORDS_PER_SECTOR)
    else $error("word index past sector end");

endmodule

/* tb/tb_ata_pio_command_sequencer_top.sv */
`timescale 1ns / 1ps

module tb_ata_pio_command_sequencer_top;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] OP_SPARE   = 2'd3;

  class pio_tracker;
    apsq_pkg::phase_t    phase;
    logic [1:0]          op;
    logic [1:0]          drive;
    logic [27:0]         blk;
    logic [7:0]          left;
    logic [8:0]          widx;
    logic [15:0]         polls;
    logic [3:0]          present;
    logic [15:0]         limit;
    apsq_pkg::out_item_t burst[$];
    apsq_pkg::out_item_t due_events[$];
    int                  errors;

    function new();
      phase   = apsq_pkg::PH_IDLE;
      op      = '0;
      drive   = '0;
      blk     = '0;
      left    = '0;
      widx    = '0;
      polls   = '0;
      present = '0;
      limit   = apsq_pkg::POLL_LIMIT_RESET;
      errors  = 0;
    endfunction

    function void set_reg(logic [apsq_pkg::CFG_IDX_W-1:0] idx,
                          logic [apsq_pkg::CFG_DATA_W-1:0] data);
      if (idx == apsq_pkg::CFG_DRIVE_MASK) begin
        present = data[3:0];
      end else begin
        limit = data;
      end
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    function logic [9:0] base();
      return drive[1] ? apsq_pkg::PORT_BASE_SEC : apsq_pkg::PORT_BASE_PRI;
    endfunction

    function void emit(logic [1:0] act, logic [9:0] prt, logic [15:0] val, logic ok);
      apsq_pkg::out_item_t r;
      r.action  = act;
      r.port    = prt;
      r.value   = val;
      r.success = ok;
      r.last    = 1'b0;
      burst.push_back(r);
    endfunction

    function void close_cmd(logic ok);
      emit(apsq_pkg::ACT_DONE, '0, '0, ok);
      phase = apsq_pkg::PH_IDLE;
    endfunction

    function void start_wait(apsq_pkg::phase_t nxt);
      polls = '0;
      if (limit == 16'd0) begin
        close_cmd(1'b0);
      end else begin
        phase = nxt;
        emit(apsq_pkg::ACT_STATUS, base() + apsq_pkg::OFS_COMMAND, '0, 1'b0);
      end
    endfunction

    function void repoll();
      polls = polls + 16'd1;
      if (polls >= limit) begin
        close_cmd(1'b0);
      end else begin
        emit(apsq_pkg::ACT_STATUS, base() + apsq_pkg::OFS_COMMAND, '0, 1'b0);
      end
    endfunction

    function void end_sector();
      left = left - 8'd1;
      if (left == 8'd0) begin
        close_cmd(1'b1);
      end else begin
        start_wait(apsq_pkg::PH_WAIT_DRQ);
      end
    endfunction

    function void take_request(apsq_pkg::in_item_t w);
      logic [7:0] sel;
      logic [7:0] st;
      burst.delete();
      st  = w.status_byte;
      sel = apsq_pkg::DEV_LBA | (drive[0] ? apsq_pkg::DEV_SLAVE : 8'h00);
      if (w.kind == apsq_pkg::KIND_START && phase == apsq_pkg::PH_IDLE) begin
        if (w.op > apsq_pkg::OP_FLUSH || !present[w.drive_num] ||
            (w.op != apsq_pkg::OP_FLUSH && w.sector_cnt == 8'd0)) begin
          emit(apsq_pkg::ACT_DONE, '0, '0, 1'b0);
        end else begin
          op    = w.op;
          drive = w.drive_num;
          blk   = w.lba;
          left  = (w.op == apsq_pkg::OP_FLUSH) ? 8'd1 : w.sector_cnt;
          widx  = '0;
          start_wait(apsq_pkg::PH_WAIT_READY);
        end
      end else if (w.kind == apsq_pkg::KIND_STATUS && phase == apsq_pkg::PH_WAIT_READY) begin
        if ((st & apsq_pkg::STS_BSY) != 8'h00) begin
          repoll();
        end else if (op == apsq_pkg::OP_FLUSH) begin
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_DEVICE, {8'h00, sel}, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_COMMAND,
               {8'h00, apsq_pkg::CMD_FLUSH}, 1'b0);
          start_wait(apsq_pkg::PH_WAIT_DONE);
        end else begin
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_DEVICE,
               {8'h00, sel | {4'h0, blk[27:24]}}, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_FEATURES, '0, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_COUNT, {8'h00, left}, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_LBA_LO, {8'h00, blk[7:0]}, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_LBA_MID, {8'h00, blk[15:8]}, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_LBA_HI, {8'h00, blk[23:16]}, 1'b0);
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_COMMAND,
               {8'h00, (op == apsq_pkg::OP_WRITE) ? apsq_pkg::CMD_WRITE : apsq_pkg::CMD_READ},
               1'b0);
          start_wait(apsq_pkg::PH_WAIT_DRQ);
        end
      end else if (w.kind == apsq_pkg::KIND_STATUS && phase == apsq_pkg::PH_WAIT_DRQ) begin
        if ((st & apsq_pkg::STS_ERR) != 8'h00 || st == apsq_pkg::STS_NONE ||
            st == apsq_pkg::STS_FLOAT || (st & apsq_pkg::STS_DF) != 8'h00) begin
          close_cmd(1'b0);
        end else if ((st & apsq_pkg::STS_BSY) == 8'h00 &&
                     (st & apsq_pkg::STS_DRQ) != 8'h00) begin
          phase = apsq_pkg::PH_TRANSFER;
          widx  = '0;
        end else begin
          repoll();
        end
      end else if (w.kind == apsq_pkg::KIND_STATUS && phase == apsq_pkg::PH_WAIT_DONE) begin
        if ((st & apsq_pkg::STS_BSY) != 8'h00) begin
          repoll();
        end else begin
          end_sector();
        end
      end else if (w.kind == apsq_pkg::KIND_DATA && phase == apsq_pkg::PH_TRANSFER) begin
        if (op == apsq_pkg::OP_WRITE) begin
          emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_DATA, w.data_word, 1'b0);
        end else begin
          emit(apsq_pkg::ACT_DATA, '0, w.data_word, 1'b0);
        end
        widx = widx + 9'd1;
        if (widx >= apsq_pkg::WORDS_PER_SECTOR) begin
          widx = '0;
          if (op == apsq_pkg::OP_WRITE) begin
            emit(apsq_pkg::ACT_PORT, base() + apsq_pkg::OFS_COMMAND,
                 {8'h00, apsq_pkg::CMD_FLUSH}, 1'b0);
            start_wait(apsq_pkg::PH_WAIT_DONE);
          end else begin
            end_sector();
          end
        end
      end
      if (burst.size() > 0) begin
        burst[burst.size() - 1].last = 1'b1;
      end
      foreach (burst[i]) begin
        due_events.push_back(burst[i]);
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task match_event(apsq_pkg::out_item_t got);
      apsq_pkg::out_item_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected word action %0d port %0h value %0h",
                         got.action, got.port, got.value));
        return;
      end
      want = due_events.pop_front();
      if (got.action !== want.action) begin
        report($sformatf("action %0d, expected %0d", got.action, want.action));
      end
      if (got.port !== want.port) begin
        report($sformatf("port %0h, expected %0h", got.port, want.port));
      end
      if (got.value !== want.value) begin
        report($sformatf("value %0h, expected %0h", got.value, want.value));
      end
      if (got.success !== want.success) begin
        report($sformatf("success %0b, expected %0b", got.success, want.success));
      end
      if (got.last !== want.last) begin
        report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_ready;
  apsq_pkg::in_item_t              req = '0;
  logic                            rsp_valid;
  logic                            rsp_ready = 1'b0;
  apsq_pkg::out_item_t             rsp;
  logic                            cfg_we = 1'b0;
  logic [apsq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [apsq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  bit                              idle_en = 1'b1;
  bit                              stall_en = 1'b1;
  int                              grants = 0;
  pio_tracker                      sb;

  ata_pio_command_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ready <= stall_en ? ($urandom_range(99) >= 36) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        sb.take_request(req);
      end
      if (rsp_valid && rsp_ready) begin
        sb.match_event(rsp);
      end
    end
  end

  function automatic apsq_pkg::in_item_t any_word();
    apsq_pkg::in_item_t w;
    w.kind        = 2'($urandom);
    w.op          = 2'($urandom);
    w.drive_num   = 2'($urandom);
    w.lba         = 28'($urandom);
    w.sector_cnt  = 8'($urandom);
    w.status_byte = 8'($urandom);
    w.data_word   = 16'($urandom);
    return w;
  endfunction

  function automatic apsq_pkg::in_item_t start_word(logic [1:0] op, logic [1:0] drv,
                                                    logic [27:0] lba, logic [7:0] cnt);
    apsq_pkg::in_item_t w;
    w            = any_word();
    w.kind       = apsq_pkg::KIND_START;
    w.op         = op;
    w.drive_num  = drv;
    w.lba        = lba;
    w.sector_cnt = cnt;
    return w;
  endfunction

  function automatic apsq_pkg::in_item_t status_item(logic [7:0] st);
    apsq_pkg::in_item_t w;
    w             = any_word();
    w.kind        = apsq_pkg::KIND_STATUS;
    w.status_byte = st;
    return w;
  endfunction

  function automatic apsq_pkg::in_item_t data_item(logic [15:0] d);
    apsq_pkg::in_item_t w;
    w           = any_word();
    w.kind      = apsq_pkg::KIND_DATA;
    w.data_word = d;
    return w;
  endfunction

  task automatic send_word(input apsq_pkg::in_item_t w);
    while (idle_en && $urandom_range(99) < 36) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req       = w;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [apsq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apsq_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(input logic [3:0] mask, input logic [15:0] lim);
    drain();
    repeat (6) @(negedge clk);
    write_reg(apsq_pkg::CFG_DRIVE_MASK, {12'($urandom), mask});
    write_reg(apsq_pkg::CFG_POLL_LIMIT, lim);
  endtask

  task automatic run_traffic(input int budget);
    int                 ctl;
    int                 pick;
    bit                 wind;
    apsq_pkg::in_item_t w;
    logic [7:0]         st;
    ctl = 0;
    while (ctl < budget || sb.phase != apsq_pkg::PH_IDLE) begin
      wind = (ctl >= budget);
      st   = 8'($urandom);
      pick = $urandom_range(9);
      if (!wind && $urandom_range(99) < 4) begin
        w = any_word();
      end else begin
        case (sb.phase)
          apsq_pkg::PH_IDLE: begin
            w = any_word();
            w.kind = apsq_pkg::KIND_START;
            if (pick != 0) w.op = 2'($urandom_range(2));
            case ($urandom_range(9))
              0: w.sector_cnt = 8'd0;
              1: w.sector_cnt = 8'hFF;
              2: w.sector_cnt = 8'($urandom);
              default: w.sector_cnt = 8'($urandom_range(1, 3));
            endcase
          end
          apsq_pkg::PH_WAIT_DRQ: begin
            if (!wind && grants > 0 && pick < 4) begin
              st = (st & ~(apsq_pkg::STS_BSY | apsq_pkg::STS_DF | apsq_pkg::STS_ERR)) |
                   apsq_pkg::STS_DRQ;
              grants--;
            end else if (wind || pick < 6) begin
              case ($urandom_range(3))
                0: st = st | apsq_pkg::STS_ERR;
                1: st = apsq_pkg::STS_NONE;
                2: st = apsq_pkg::STS_FLOAT;
                default: st = (st & ~apsq_pkg::STS_ERR) | apsq_pkg::STS_DF;
              endcase
            end else begin
              st = st & ~(apsq_pkg::STS_ERR | apsq_pkg::STS_DF);
              if ((st & apsq_pkg::STS_BSY) == 8'h00 && (st & apsq_pkg::STS_DRQ) != 8'h00) begin
                st = st | apsq_pkg::STS_BSY;
              end
              if (st == apsq_pkg::STS_NONE) st = apsq_pkg::STS_BSY;
            end
            w = status_item(st);
          end
          apsq_pkg::PH_TRANSFER: begin
            w = data_item(16'($urandom));
          end
          default: begin
            if (wind || pick < 7) begin
              st = st & ~apsq_pkg::STS_BSY;
            end else begin
              st = st | apsq_pkg::STS_BSY;
            end
            w = status_item(st);
          end
        endcase
      end
      send_word(w);
      if (w.kind != apsq_pkg::KIND_DATA) ctl++;
      if (!wind && $urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    apsq_pkg::in_item_t w;
    sb = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_word(start_word(apsq_pkg::OP_READ, 2'd0, 28'($urandom), 8'd5));
    send_word(status_item(8'($urandom)));
    w = any_word();
    w.kind = KIND_SPARE;
    send_word(w);

    set_config(4'b0111, 16'd2);
    send_word(start_word(apsq_pkg::OP_READ, 2'd3, 28'($urandom), 8'd1));
    send_word(start_word(OP_SPARE, 2'd0, 28'($urandom), 8'd1));
    send_word(start_word(apsq_pkg::OP_READ, 2'd0, 28'($urandom), 8'd0));
    send_word(start_word(apsq_pkg::OP_FLUSH, 2'd2, 28'hFFFFFFF, 8'd0));
    send_word(status_item(apsq_pkg::STS_BSY));
    send_word(status_item(apsq_pkg::STS_FLOAT));
    send_word(status_item(8'($urandom)));
    send_word(start_word(apsq_pkg::OP_WRITE, 2'd1, 28'hFFFFFFF, 8'hFF));
    send_word(status_item(8'h7F));
    send_word(start_word(apsq_pkg::OP_READ, 2'd0, 28'($urandom), 8'd1));
    send_word(data_item(16'hFFFF));
    send_word(status_item(apsq_pkg::STS_BSY | apsq_pkg::STS_DRQ));
    send_word(status_item(8'h02));
    send_word(start_word(apsq_pkg::OP_READ, 2'd2, 28'h0ABCDEF, 8'd1));
    send_word(status_item(apsq_pkg::STS_NONE));
    send_word(status_item(apsq_pkg::STS_ERR));
    send_word(start_word(apsq_pkg::OP_READ, 2'd0, 28'h0000000, 8'd2));
    send_word(status_item(8'h40));
    send_word(status_item(apsq_pkg::STS_NONE));
    send_word(start_word(apsq_pkg::OP_WRITE, 2'd1, 28'($urandom), 8'd1));
    send_word(status_item(8'h50));
    send_word(status_item(apsq_pkg::STS_DF));
    send_word(start_word(apsq_pkg::OP_READ, 2'd2, 28'($urandom), 8'd3));
    send_word(status_item(apsq_pkg::STS_NONE));
    send_word(status_item(apsq_pkg::STS_FLOAT));
    send_word(start_word(apsq_pkg::OP_FLUSH, 2'd0, 28'($urandom), 8'hFF));
    send_word(status_item(8'h50));
    send_word(status_item(8'h50));

    set_config(4'hF, 16'd3);
    run_traffic(14);
    set_config(4'h0, 16'd1);
    run_traffic(3);
    set_config(4'($urandom), 16'd1);
    run_traffic(6);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    grants   = 1;
    set_config(4'hF, 16'hFFFF);
    run_traffic(12);
    idle_en  = 1'b1;
    stall_en = 1'b1;
    set_config(4'hF, 16'd0);
    run_traffic(4);
    set_config(4'($urandom), 16'($urandom_range(1, 6)));
    run_traffic(14);

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("FAIL");
    $finish;
  end

endmodule

/* ata_pio_command_sequencer_top.f */
src/apsq_pkg.sv
src/apsq_step.sv
src/ata_pio_command_sequencer_top.sv
tb/tb_ata_pio_command_sequencer_top.sv
